### src/nearest_point_table_search_top_defines.svh
// Assertion macros used by the nearest-point table search back end.
`ifndef NEAREST_POINT_TABLE_SEARCH_TOP_DEFINES_SVH
`define NEAREST_POINT_TABLE_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define NPTS_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define NPTS_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/npts_pkg.sv
// Package: sizes, codes, item types and helpers of the nearest-point table search.
`default_nettype none

package npts_pkg;

  // Table size and coordinate precision
  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 16;

  // Fixed field widths of the item ports
  localparam int IN_COORD_W = 16;
  localparam int RANGE_W    = 17;
  localparam int OUT_IDX_W  = 6;
  localparam int DIST_W     = 17;
  localparam int OUT_MASK_W = 64;
  localparam int OUT_CNT_W  = 7;

  // Derived widths
  localparam int CW     = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int RSQ_W  = 2 * RANGE_W;
  localparam int SQ_W   = 2 * CW + 1;
  localparam int RT_W   = CW + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Item kinds on the input port
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Classified operations handed to the back end
  typedef logic [1:0] op_t;
  localparam op_t OP_NONE  = 2'd0;
  localparam op_t OP_ADD   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam op_t OP_QUERY = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [IN_COORD_W-1:0] point_x;
    logic [IN_COORD_W-1:0] point_y;
    logic [RANGE_W-1:0]    search_range;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [OUT_IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0]     nearest_distance;
    logic [OUT_MASK_W-1:0] in_range_mask;
    logic [OUT_CNT_W-1:0]  stored_count;
    logic                  dropped;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [RSQ_W-1:0] range_sq;
  } cmd_t;

  // Absolute difference of two coordinates
  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

### src/npts_front.sv
// Front end: accepts items, classifies them and queues commands for the back end.
`default_nettype none

module npts_front import npts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cmd_new;
  logic              wr_en;
  logic              rd_en;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // Classify the item; square the range once here
  always_comb begin
    cmd_new.x        = in_item.point_x[CW-1:0];
    cmd_new.y        = in_item.point_y[CW-1:0];
    cmd_new.range_sq = RSQ_W'(in_item.search_range) * RSQ_W'(in_item.search_range);
    unique case (in_item.kind)
      KIND_ADD:   cmd_new.op = OP_ADD;
      KIND_CLEAR: cmd_new.op = OP_CLEAR;
      KIND_QUERY: cmd_new.op = OP_QUERY;
      default:    cmd_new.op = OP_NONE;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/npts_isqrt.sv
// Iterative integer square root, one root bit per cycle.
`default_nettype none

module npts_isqrt import npts_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output logic            done,
  output logic [RT_W-1:0] root
);

  localparam int REM_W  = RT_W + 3;
  localparam int RAD_W  = 2 * RT_W;
  localparam int STEP_W = $clog2(RT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [RT_W-1:0]   root_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic              last;

  // Bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign ge     = (rem_sh >= trial);
  assign last   = (step_r == STEP_W'(RT_W - 1));

  assign done = done_r;
  assign root = root_r;

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### src/npts_back.sv
// Back end: point table, query scan pipeline, root unit and result register.
`default_nettype none

`include "nearest_point_table_search_top_defines.svh"

module npts_back import npts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CNT_W-1:0]    issue_r;
  logic [2*CW-1:0]     mem [CAPACITY];
  logic [2*CW-1:0]     rd_data_r;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                v1_r;
  logic                v2_r;
  logic                v3_r;
  logic [IDX_W-1:0]    t1_r;
  logic [IDX_W-1:0]    t2_r;
  logic [IDX_W-1:0]    t3_r;
  logic [CW-1:0]       qx_r;
  logic [CW-1:0]       qy_r;
  logic [RSQ_W-1:0]    rsq_r;
  logic [CW-1:0]       dx_r;
  logic [CW-1:0]       dy_r;
  logic [2*CW-1:0]     dx2_r;
  logic [2*CW-1:0]     dy2_r;
  logic [SQ_W-1:0]     sq;
  logic [SQ_W-1:0]     best_r;
  logic [IDX_W-1:0]    bidx_r;
  logic [CAPACITY-1:0] mask_r;
  logic                is_full;
  logic                start_scan;
  logic                scan_end;
  logic                sq_done;
  logic [RT_W-1:0]     sq_root;
  logic [DIST_W-1:0]   dist_sat;
  out_item_t           take_res;
  out_item_t           query_res;
  out_item_t           res_r;
  logic                res_valid_r;

  // Take a command only with the result register free
  assign cmd_take   = (state_r == ST_IDLE) && cmd_valid && !res_valid_r;
  assign is_full    = (count_r == CNT_W'(CAPACITY));
  assign start_scan = cmd_take && (cmd.op == OP_QUERY) && (count_r != '0);
  assign rd_en      = (state_r == ST_SCAN) && (issue_r < count_r);
  assign rd_addr    = issue_r[IDX_W-1:0];
  assign scan_end   = (state_r == ST_SCAN) && !rd_en && !v1_r && !v2_r && !v3_r;
  assign sq         = SQ_W'(dx2_r) + SQ_W'(dy2_r);
  assign dist_sat   = (32'(sq_root) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq_root);

  assign empty    = !res_valid_r;
  assign out_item = res_r;

  // Entry count after the command now taken
  always_comb begin
    unique case (cmd.op)
      OP_ADD:   count_nxt = is_full ? count_r : count_r + 1'b1;
      OP_CLEAR: count_nxt = '0;
      OP_QUERY: count_nxt = count_r;
      OP_NONE:  count_nxt = count_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start_scan) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end)   state_nxt = ST_ROOT;
      ST_ROOT: if (sq_done)    state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Point table: one write port for adds, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd_take && (cmd.op == OP_ADD) && !is_full) begin
      mem[count_r[IDX_W-1:0]] <= {cmd.x, cmd.y};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (cmd_take) begin
        count_r <= count_nxt;
      end
      if (start_scan) begin
        issue_r <= '0;
      end else if (rd_en) begin
        issue_r <= issue_r + 1'b1;
      end
      if ((cmd_take && !start_scan) || ((state_r == ST_ROOT) && sq_done)) begin
        res_valid_r <= 1'b1;
      end else if (pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Scan pipeline: read, differences, squares, compare
  always_ff @(posedge clk) begin
    t1_r  <= rd_addr;
    t2_r  <= t1_r;
    t3_r  <= t2_r;
    dx_r  <= abs_diff(rd_data_r[2*CW-1:CW], qx_r);
    dy_r  <= abs_diff(rd_data_r[CW-1:0], qy_r);
    dx2_r <= dx_r * dx_r;
    dy2_r <= dy_r * dy_r;
    if (start_scan) begin
      qx_r   <= cmd.x;
      qy_r   <= cmd.y;
      rsq_r  <= cmd.range_sq;
      mask_r <= '0;
    end
    if (v3_r) begin
      // strict less keeps the lowest index on a tie
      if ((t3_r == '0) || (sq < best_r)) begin
        best_r <= sq;
        bidx_r <= t3_r;
      end
      if (RSQ_W'(sq) < rsq_r) begin
        mask_r[t3_r] <= 1'b1;
      end
    end
  end

  // Result of a command finished at take: only count and drop flag
  always_comb begin
    take_res              = '0;
    take_res.stored_count = OUT_CNT_W'(count_nxt);
    take_res.dropped      = (cmd.op == OP_ADD) && is_full;
  end

  // Result of a finished query scan
  always_comb begin
    query_res                  = '0;
    query_res.found            = 1'b1;
    query_res.nearest_index    = OUT_IDX_W'(bidx_r);
    query_res.nearest_distance = dist_sat;
    query_res.in_range_mask    = OUT_MASK_W'(mask_r);
    query_res.stored_count     = OUT_CNT_W'(count_r);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_r <= take_res;
    end else if ((state_r == ST_ROOT) && sq_done) begin
      res_r <= query_res;
    end
  end

  npts_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_end),
    .radicand (best_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Checks
  `NPTS_AST_SAME(a_no_result_mid_query, state_r != ST_IDLE, !res_valid_r,
                 "result pending during query")
  `NPTS_AST_SAME(a_root_only_in_root, sq_done, state_r == ST_ROOT,
                 "root done outside root state")
  `NPTS_AST_NEXT(a_clear_empties, cmd_take && cmd.op == OP_CLEAR, count_r == '0,
                 "clear left entries")
  `NPTS_AST_NEXT(a_add_grows, cmd_take && cmd.op == OP_ADD && !is_full,
                 count_r == $past(count_r) + 1'b1, "add did not grow table")

endmodule

`default_nettype wire

### src/nearest_point_table_search_top.sv
// Top level of the nearest-point table search.
// A table of up to 64 points (Q12.4) takes add, clear and query items through a
// two-entry command queue and returns one result item per input item. Add, clear,
// unused kinds and a query of an empty table have their result registered when the
// back end takes the command. A query of a non-empty table first scans it: the scan
// reads one entry per cycle from the table's single read port through a four-stage
// distance pipeline, then the square root of the best squared distance is formed
// one bit per cycle. Only one command runs in the back end at a time and the next
// one is taken only after the result is popped; the input queue and the result
// register let the producer and consumer stall independently.
`default_nettype none

module nearest_point_table_search_top import npts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  npts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  npts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### tb/nearest_point_table_search_top_test.sv
// Testbench for the nearest-point table search: directed and random items checked by a table model.
`timescale 1ns / 1ps

module nearest_point_table_search_top_test;
  import npts_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  nearest_point_table_search_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // Items waiting to be offered, results still owed by the block
  in_item_t  item_queue[$];
  out_item_t owed_results[$];

  // Shadow copy of the point table
  logic [CW-1:0] table_x [CAPACITY];
  logic [CW-1:0] table_y [CAPACITY];
  int            table_count = 0;

  int total_items = 1;
  int items_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Truncated square root, one bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Apply one item to the shadow table and return the result it must produce
  function automatic out_item_t search_table(in_item_t it);
    out_item_t       res;
    logic [CW-1:0]   px;
    logic [CW-1:0]   py;
    longint unsigned dx, dy, sq, best_sq, range_sq, root;
    res = '0;
    px = it.point_x[CW-1:0];
    py = it.point_y[CW-1:0];
    best_sq = 0;
    case (it.kind)
      KIND_ADD: begin
        if (table_count >= CAPACITY) begin
          res.dropped = 1'b1;
        end else begin
          table_x[table_count] = px;
          table_y[table_count] = py;
          table_count++;
        end
      end
      KIND_CLEAR: begin
        table_count = 0;
      end
      KIND_QUERY: begin
        range_sq = 64'(it.search_range) * 64'(it.search_range);
        for (int i = 0; i < table_count; i++) begin
          dx = (table_x[i] > px) ? 64'(table_x[i] - px) : 64'(px - table_x[i]);
          dy = (table_y[i] > py) ? 64'(table_y[i] - py) : 64'(py - table_y[i]);
          sq = dx * dx + dy * dy;
          // strict compare keeps the lowest index on a tie
          if (i == 0 || sq < best_sq) begin
            best_sq = sq;
            res.nearest_index = OUT_IDX_W'(i);
          end
          if (sq < range_sq) res.in_range_mask[i] = 1'b1;
        end
        if (table_count > 0) begin
          res.found = 1'b1;
          root = floor_root(best_sq);
          res.nearest_distance = (root > 64'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
        end
      end
      default: ;
    endcase
    res.stored_count = OUT_CNT_W'(table_count);
    return res;
  endfunction

  function automatic void queue_item(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                                     logic [RANGE_W-1:0] r);
    in_item_t it;
    it.kind = kind;
    it.point_x = x;
    it.point_y = y;
    it.search_range = r;
    item_queue = {item_queue, it};
  endfunction

  // Coordinate: anywhere, at an edge of the plane, or near a cluster center
  function automatic logic [15:0] pick_coord(int mode, logic [15:0] center);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return center + 16'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return RANGE_W'(92682);
      3: return RANGE_W'($urandom_range(0, 131071));
      4: return RANGE_W'($urandom_range(0, 48));
      default: return RANGE_W'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic int coord_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return 2;
    return 1;
  endfunction

  // Idling phases follow the share of items already taken by the block
  function automatic int stall_phase();
    int p;
    p = items_accepted * 4 / total_items;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic bit sender_idles();
    case (stall_phase())
      1: return $urandom_range(0, 99) < 70;
      3: return $urandom_range(0, 99) < 31;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (stall_phase())
      2: return $urandom_range(0, 99) < 70;
      3: return $urandom_range(0, 99) < 31;
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_result(out_item_t want, out_item_t got);
    if (got.found !== want.found || got.nearest_index !== want.nearest_index ||
        got.nearest_distance !== want.nearest_distance ||
        got.in_range_mask !== want.in_range_mask ||
        got.stored_count !== want.stored_count || got.dropped !== want.dropped) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d mismatch (expected/actual): found %0b/%0b index %0d/%0d",
                 results_seen, want.found, got.found, want.nearest_index, got.nearest_index);
        $display("  distance %0d/%0d mask %h/%h count %0d/%0d dropped %0b/%0b",
                 want.nearest_distance, got.nearest_distance, want.in_range_mask,
                 got.in_range_mask, want.stored_count, got.stored_count,
                 want.dropped, got.dropped);
      end
    end
  endtask

  // Driver: offers the head of the item queue, predicts each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_item <= '0;
    end else begin
      if (push && !full) begin
        owed_results = {owed_results, search_table(item_queue.pop_front())};
        items_accepted <= items_accepted + 1;
      end
      if (item_queue.size() > 0 && !sender_idles()) begin
        push <= 1'b1;
        in_item <= item_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: takes results, checks them, stalls at random and once for a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: found %0b index %0d distance %0d count %0d",
                     out_item.found, out_item.nearest_index, out_item.nearest_distance,
                     out_item.stored_count);
        end else begin
          check_result(owed_results.pop_front(), out_item);
        end
      end
      if (!pressure_done && results_seen == 30) begin
        pressure_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= !receiver_stalls();
      end
    end
  end

  // Watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int            counted;
    int            burst;
    int            r;
    logic [15:0]   cx, cy, last_x, last_y;

    cx = 16'($urandom_range(0, 65535));
    cy = 16'($urandom_range(0, 65535));

    // Directed: empty table, unused kind, corners, ties, range boundaries, clear
    queue_item(KIND_QUERY, 16'h0000, 16'h0000, '1);
    queue_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, '1);
    queue_item(KIND_ADD, 16'h0000, 16'h0000, '0);
    queue_item(KIND_ADD, 16'hFFFF, 16'hFFFF, '1);
    queue_item(KIND_ADD, 16'hFFFF, 16'h0000, '0);
    queue_item(KIND_ADD, 16'h0000, 16'hFFFF, '0);
    queue_item(KIND_QUERY, 16'h0000, 16'h0000, '0);
    queue_item(KIND_QUERY, 16'hFFFF, 16'hFFFF, '1);
    queue_item(KIND_QUERY, 16'h8000, 16'h7FFF, RANGE_W'(92682));
    queue_item(KIND_ADD, 16'd100, 16'd200, '0);
    queue_item(KIND_ADD, 16'd100, 16'd200, '0);
    queue_item(KIND_QUERY, 16'd100, 16'd200, RANGE_W'(1));
    queue_item(KIND_QUERY, 16'd101, 16'd200, RANGE_W'(1));
    queue_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, '1);
    queue_item(KIND_QUERY, 16'd100, 16'd200, '1);
    queue_item(KIND_ADD, 16'hFFFF, 16'hFFFF, '0);
    // farthest corner: distance 92680, squared just under 92681^2
    queue_item(KIND_QUERY, 16'h0000, 16'h0000, RANGE_W'(92681));
    queue_item(KIND_QUERY, 16'h0000, 16'h0000, RANGE_W'(92680));
    queue_item(KIND_UNUSED, 16'h0000, 16'h0000, '0);
    queue_item(KIND_ADD, 16'h5555, 16'hAAAA, '0);
    queue_item(KIND_QUERY, 16'hAAAA, 16'h5555, RANGE_W'(65536));
    queue_item(KIND_CLEAR, 16'h0000, 16'h0000, '0);

    // Fill past capacity once so full-table adds are certain
    counted = 0;
    last_x = cx;
    last_y = cy;
    for (int i = 0; i < 68; i++) begin
      last_x = pick_coord(coord_mode(), cx);
      last_y = pick_coord(coord_mode(), cy);
      queue_item(KIND_ADD, last_x, last_y, pick_range());
      counted++;
      if (i % 8 == 7) begin
        queue_item(KIND_QUERY, last_x + 16'($urandom_range(0, 6)) - 16'd3, last_y,
                   pick_range());
        counted++;
      end
    end

    // Random mix of adds, queries, clears and the odd unused kind
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        queue_item(KIND_UNUSED, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   RANGE_W'($urandom_range(0, 131071)));
        counted++;
      end else if (r < 9) begin
        queue_item(KIND_CLEAR, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   pick_range());
        counted++;
        if ($urandom_range(0, 4) == 0) begin
          burst = $urandom_range(50, 70);
          for (int i = 0; i < burst; i++) begin
            last_x = pick_coord(coord_mode(), cx);
            last_y = pick_coord(coord_mode(), cy);
            queue_item(KIND_ADD, last_x, last_y, pick_range());
            counted++;
          end
        end
      end else if (r < 50) begin
        last_x = pick_coord(coord_mode(), cx);
        last_y = pick_coord(coord_mode(), cy);
        queue_item(KIND_ADD, last_x, last_y, pick_range());
        counted++;
      end else begin
        // query near the last point added, or anywhere
        if ($urandom_range(0, 99) < 40)
          queue_item(KIND_QUERY, last_x + 16'($urandom_range(0, 6)) - 16'd3,
                     last_y + 16'($urandom_range(0, 6)) - 16'd3, pick_range());
        else
          queue_item(KIND_QUERY, pick_coord(coord_mode(), cx), pick_coord(coord_mode(), cy),
                     pick_range());
        counted++;
      end
    end
    total_items = item_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all items taken and every owed result returned
    while (item_queue.size() != 0 || owed_results.size() != 0 || push) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
